// File: rtl/sync_framed_packet_decimator_assert.svh
// Assertion macros used by the checker of the packet decimator.
`ifndef SYNC_FRAMED_PACKET_DECIMATOR_ASSERT_SVH
`define SYNC_FRAMED_PACKET_DECIMATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SFPD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("packet decimator check failed");

// Consequent must hold in the cycle after the antecedent.
`define SFPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("packet decimator check failed");

`endif

// File: rtl/sfpd_pkg.sv
// Shared constants and types of the sync-framed packet decimator.
package sfpd_pkg;

  // Per-id table geometry.
  localparam int unsigned TableDepth = 1024;
  localparam int unsigned TableAw    = (TableDepth > 1) ? $clog2(TableDepth) : 1;

  // Command queue between the parser and the result sequencer.
  localparam int unsigned CmdDepth = 4;
  localparam int unsigned CmdAw    = $clog2(CmdDepth);

  // Framing constants.
  localparam logic [7:0] SyncByte = 8'hAA;
  localparam int unsigned HdrBytes = 6;

  // One unit of work for the result sequencer: a full header burst or one body byte.
  typedef struct packed {
    logic                is_header;
    logic [5:0][7:0]     hdr;
    logic [9:0]          id;
    logic                fwd;
    logic                len_err;
    logic                eop;
  } cmd_t;

endpackage

// File: rtl/sfpd_ram.sv
// Generic single-port-write, one-read-port RAM with registered read data.
module sfpd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/sfpd_cmd_fifo.sv
// Short command queue that decouples the parser from the result sequencer.
module sfpd_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sfpd_pkg::cmd_t data_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          empty_o,
  output sfpd_pkg::cmd_t data_o
);

  sfpd_pkg::cmd_t               mem_q [sfpd_pkg::CmdDepth];
  logic [sfpd_pkg::CmdAw-1:0]   wr_ptr_q, rd_ptr_q;
  logic [sfpd_pkg::CmdAw:0]     cnt_q, cnt_d;
  logic                         do_push, do_pop;

  assign full_o  = (cnt_q == (sfpd_pkg::CmdAw+1)'(sfpd_pkg::CmdDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  // Occupancy follows pushes and pops.
  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // Pointers and count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == sfpd_pkg::CmdAw'(sfpd_pkg::CmdDepth - 1)) ? '0
                                                                          : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == sfpd_pkg::CmdAw'(sfpd_pkg::CmdDepth - 1)) ? '0
                                                                          : rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: rtl/sfpd_front.sv
// Parser front end: sync search, header capture, per-id table and forward decision.
module sfpd_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic           action_i,
  input  logic [7:0]     data_byte_i,
  input  logic           clear_to_send_i,
  input  logic [9:0]     entry_index_i,
  input  logic [15:0]    entry_size_i,
  input  logic [15:0]    entry_decimation_i,
  output logic           clearing_o,
  output logic           cmd_push_o,
  output sfpd_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    PH_SEEK1  = 4'b0001,
    PH_SEEK2  = 4'b0010,
    PH_HEADER = 4'b0100,
    PH_BODY   = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [15:0] size;
    logic [15:0] rate;
    logic [15:0] skip;
    logic        reported;
  } entry_t;

  localparam int unsigned EntryW  = $bits(entry_t);
  localparam logic [2:0]  HdrLast = 3'(sfpd_pkg::HdrBytes - 1);
  localparam logic [10:0] DepthLim = 11'(sfpd_pkg::TableDepth);

  phase_e                       phase_q, phase_d;
  logic [2:0]                   hcnt_q, hcnt_d;
  logic [7:0]                   store_q [sfpd_pkg::HdrBytes];
  logic [16:0]                  body_rem_q, body_rem_d;
  logic                         sel_q, sel_d;
  logic                         err_q, err_d;
  entry_t                       entry_q, entry_d;
  logic                         ent_pend_q;
  logic                         clr_q;
  logic [sfpd_pkg::TableAw-1:0] clr_cnt_q;

  logic                         stream_acc, define_acc, hdr_acc, hdr_end, body_acc, id_issue;
  logic [9:0]                   cur_id, rd_id;
  logic                         cur_in_rng, def_in_rng, def_hits_cur;
  entry_t                       def_ent, upd_ent, rd_ent;
  logic [EntryW-1:0]            ram_rdata, ram_wdata;
  logic [sfpd_pkg::TableAw-1:0] ram_waddr;
  logic                         ram_we;
  logic [15:0]                  hdr_len, skip_dec;
  logic [16:0]                  expect_len, rem_dec;
  logic                         mismatch, new_err, can_fwd, new_sel, eop;

  // Item classification.
  assign stream_acc = accept_i & ~action_i;
  assign define_acc = accept_i & action_i;
  assign hdr_acc    = stream_acc & (phase_q == PH_HEADER);
  assign hdr_end    = hdr_acc & (hcnt_q == HdrLast);
  assign body_acc   = stream_acc & (phase_q == PH_BODY);
  assign id_issue   = hdr_acc & (hcnt_q == 3'd1);

  assign cur_id     = {store_q[1][1:0], store_q[0]};
  assign rd_id      = {data_byte_i[1:0], store_q[0]};
  assign cur_in_rng = ({1'b0, cur_id} < DepthLim);
  assign def_in_rng = ({1'b0, entry_index_i} < DepthLim);

  // A define item rewrites the whole entry and rearms the skip counter.
  always_comb begin
    def_ent.size     = entry_size_i;
    def_ent.rate     = entry_decimation_i;
    def_ent.skip     = {15'b0, |entry_decimation_i};
    def_ent.reported = 1'b0;
  end

  // A define aimed at the id being parsed must also reach the held entry.
  assign def_hits_cur = define_acc & (phase_q == PH_HEADER) & (hcnt_q >= 3'd2) &
                        (entry_index_i == cur_id);

  assign rd_ent = entry_t'(ram_rdata);

  always_comb begin
    if (def_hits_cur) begin
      entry_d = def_ent;
    end else if (ent_pend_q) begin
      entry_d = rd_ent;
    end else begin
      entry_d = entry_q;
    end
  end

  // Length check and decimation at the last header byte.
  assign hdr_len    = {data_byte_i, store_q[4]};
  assign expect_len = {1'b0, entry_q.size} + 17'd6;
  assign mismatch   = (expect_len != {1'b0, hdr_len});
  assign new_err    = cur_in_rng & mismatch & ~entry_q.reported;
  assign can_fwd    = cur_in_rng & clear_to_send_i & (entry_q.size != '0) &
                      (entry_q.rate != '0);
  assign skip_dec   = entry_q.skip - 16'd1;
  assign new_sel    = can_fwd & (skip_dec == '0);

  always_comb begin
    upd_ent          = entry_q;
    upd_ent.reported = entry_q.reported | new_err;
    if (can_fwd) begin
      upd_ent.skip = (skip_dec == '0) ? entry_q.rate : skip_dec;
    end
  end

  // Table write port: clearing pass, define items, header write-back.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_cnt_q;
    ram_wdata = '0;
    if (clr_q) begin
      ram_we = 1'b1;
    end else if (define_acc && def_in_rng) begin
      ram_we    = 1'b1;
      ram_waddr = entry_index_i[sfpd_pkg::TableAw-1:0];
      ram_wdata = def_ent;
    end else if (hdr_end && cur_in_rng) begin
      ram_we    = 1'b1;
      ram_waddr = cur_id[sfpd_pkg::TableAw-1:0];
      ram_wdata = upd_ent;
    end
  end

  sfpd_ram #(
    .Width (EntryW),
    .Depth (sfpd_pkg::TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_id[sfpd_pkg::TableAw-1:0]),
    .rdata_o (ram_rdata)
  );

  // Body byte countdown.
  assign rem_dec = (body_rem_q != '0) ? body_rem_q - 17'd1 : body_rem_q;
  assign eop     = (rem_dec == '0);

  // Parse phase sequencing.
  always_comb begin
    phase_d    = phase_q;
    hcnt_d     = hcnt_q;
    body_rem_d = body_rem_q;
    sel_d      = sel_q;
    err_d      = err_q;
    if (stream_acc) begin
      case (phase_q)
        PH_SEEK1: begin
          if (data_byte_i == sfpd_pkg::SyncByte) begin
            phase_d = PH_SEEK2;
          end
        end
        PH_SEEK2: begin
          if (data_byte_i == sfpd_pkg::SyncByte) begin
            phase_d = PH_HEADER;
            hcnt_d  = '0;
          end else begin
            phase_d = PH_SEEK1;
          end
        end
        PH_HEADER: begin
          if (hcnt_q == HdrLast) begin
            phase_d    = PH_BODY;
            hcnt_d     = '0;
            body_rem_d = {1'b0, hdr_len} + 17'd1;
            sel_d      = new_sel;
            err_d      = new_err;
          end else begin
            hcnt_d = hcnt_q + 3'd1;
          end
        end
        PH_BODY: begin
          body_rem_d = rem_dec;
          if (eop) begin
            phase_d = PH_SEEK1;
          end
        end
        default: begin
          phase_d = PH_SEEK1;
        end
      endcase
    end
  end

  // Command toward the result sequencer.
  assign cmd_push_o = hdr_end | body_acc;

  always_comb begin
    cmd_o.is_header = hdr_end;
    cmd_o.id        = cur_id;
    cmd_o.eop       = ~hdr_end & eop;
    if (hdr_end) begin
      cmd_o.hdr     = {data_byte_i, store_q[4], store_q[3], store_q[2], store_q[1],
                       store_q[0]};
      cmd_o.fwd     = new_sel;
      cmd_o.len_err = new_err;
    end else begin
      cmd_o.hdr     = {40'b0, data_byte_i};
      cmd_o.fwd     = sel_q;
      cmd_o.len_err = err_q;
    end
  end

  assign clearing_o = clr_q;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_SEEK1;
      hcnt_q     <= '0;
      body_rem_q <= '0;
      sel_q      <= 1'b0;
      err_q      <= 1'b0;
      ent_pend_q <= 1'b0;
      clr_q      <= 1'b1;
      clr_cnt_q  <= '0;
    end else begin
      phase_q    <= phase_d;
      hcnt_q     <= hcnt_d;
      body_rem_q <= body_rem_d;
      sel_q      <= sel_d;
      err_q      <= err_d;
      ent_pend_q <= id_issue;
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == sfpd_pkg::TableAw'(sfpd_pkg::TableDepth - 1)) begin
          clr_q <= 1'b0;
        end
      end
    end
  end

  // Header bytes and the held table entry.
  always_ff @(posedge clk_i) begin
    if (hdr_acc) begin
      store_q[hcnt_q] <= data_byte_i;
    end
    entry_q <= entry_d;
  end

endmodule

// File: rtl/sfpd_back.sv
// Result sequencer: expands commands into result items behind an output register.
module sfpd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  sfpd_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  input  logic           pop_i,
  output logic           empty_o,
  output logic [7:0]     out_byte_o,
  output logic           forward_o,
  output logic           length_error_o,
  output logic [9:0]     packet_id_o,
  output logic           end_of_packet_o,
  output logic           last_o
);

  localparam logic [2:0] LastBeat = 3'd7;

  logic       out_valid_q;
  logic [2:0] beat_q, beat_d;
  logic [2:0] hdr_idx;
  logic       load, take, beat_last;
  logic [7:0] byte_d;

  assign load      = ~out_valid_q | pop_i;
  assign take      = load & cmd_valid_i;
  assign beat_last = (beat_q == LastBeat);
  assign hdr_idx   = beat_q - 3'd2;

  // Byte of the current beat: two sync bytes, then the six header bytes; a body command gives its byte.
  always_comb begin
    if (!cmd_i.is_header) begin
      byte_d = cmd_i.hdr[0];
    end else if (beat_q < 3'd2) begin
      byte_d = sfpd_pkg::SyncByte;
    end else begin
      byte_d = cmd_i.hdr[hdr_idx];
    end
  end

  assign cmd_pop_o = take & (~cmd_i.is_header | beat_last);

  always_comb begin
    beat_d = beat_q;
    if (cmd_pop_o) begin
      beat_d = '0;
    end else if (take) begin
      beat_d = beat_q + 3'd1;
    end
  end

  assign empty_o = ~out_valid_q;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      beat_q      <= '0;
    end else begin
      beat_q <= beat_d;
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (take) begin
      out_byte_o      <= byte_d;
      forward_o       <= cmd_i.fwd;
      length_error_o  <= cmd_i.len_err;
      packet_id_o     <= cmd_i.id;
      end_of_packet_o <= ~cmd_i.is_header & cmd_i.eop;
      last_o          <= ~cmd_i.is_header | beat_last;
    end
  end

endmodule

// File: rtl/sync_framed_packet_decimator.sv
// Top level of the sync-framed packet decimator.
// Takes one item per cycle while full is low: a stream byte or a table define. After two
// 0xAA sync bytes and a six-byte header, the last header byte yields eight result items (sync
// and header bytes) and each body byte one more, all carrying the packet id, the forward
// decision and the first-time length error. Results pass through the command queue and an
// output register and leave at one per cycle while the receiver pops. The four-entry command
// queue lets input items keep arriving during a header burst, and full is raised while that
// queue is full: with the receiver always ready, the three body bytes that follow a header
// fill the queue and full then stays high until the burst drains. The per-id table is one
// single-port-write RAM; its entry is read as the id bytes arrive and written back at the
// last header byte. After reset, full stays high while all TableDepth (1024) table entries
// are cleared, one entry a cycle.
module sync_framed_packet_decimator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        action_i,
  input  logic [7:0]  data_byte_i,
  input  logic        clear_to_send_i,
  input  logic [9:0]  entry_index_i,
  input  logic [15:0] entry_size_i,
  input  logic [15:0] entry_decimation_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic        forward_o,
  output logic        length_error_o,
  output logic [9:0]  packet_id_o,
  output logic        end_of_packet_o,
  output logic        last_o
);

  sfpd_pkg::cmd_t push_cmd, head_cmd;
  logic           clearing, cmd_push, cmd_pop, q_full, q_empty, accept;

  // Items are refused during the clearing pass or while the queue is full.
  assign full   = clearing | q_full;
  assign accept = push & ~full;

  sfpd_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .accept_i           (accept),
    .action_i           (action_i),
    .data_byte_i        (data_byte_i),
    .clear_to_send_i    (clear_to_send_i),
    .entry_index_i      (entry_index_i),
    .entry_size_i       (entry_size_i),
    .entry_decimation_i (entry_decimation_i),
    .clearing_o         (clearing),
    .cmd_push_o         (cmd_push),
    .cmd_o              (push_cmd)
  );

  sfpd_cmd_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (push_cmd),
    .pop_i   (cmd_pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .data_o  (head_cmd)
  );

  sfpd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (~q_empty),
    .cmd_i           (head_cmd),
    .cmd_pop_o       (cmd_pop),
    .pop_i           (pop),
    .empty_o         (empty),
    .out_byte_o      (out_byte_o),
    .forward_o       (forward_o),
    .length_error_o  (length_error_o),
    .packet_id_o     (packet_id_o),
    .end_of_packet_o (end_of_packet_o),
    .last_o          (last_o)
  );

endmodule

// File: rtl/sfpd_checker.sv
// Port-level checker for the packet decimator, bound to the top level.
`include "sync_framed_packet_decimator_assert.svh"

module sfpd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [7:0]  out_byte_o,
  input logic [9:0]  packet_id_o,
  input logic        end_of_packet_o,
  input logic        last_o
);

  // The final byte of a packet always closes its item's results.
  `SFPD_ASSERT_NOW(a_eop_is_last, !empty && end_of_packet_o, last_o)

  // A header burst is delivered without gaps once its first result is taken.
  `SFPD_ASSERT_NEXT(a_burst_contiguous, !empty && pop && !last_o, !empty)

  // All results of one header burst report the same packet id.
  `SFPD_ASSERT_NEXT(a_burst_same_id, !empty && pop && !last_o, $stable(packet_id_o))

  // A waiting result holds until it is taken.
  `SFPD_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(out_byte_o))

endmodule

bind sync_framed_packet_decimator sfpd_checker u_checker (.*);

// File: tb/sv/tb_sync_framed_packet_decimator.sv
// Self-checking testbench for the sync-framed packet decimator.

typedef enum logic [1:0] {
  SEEK_FIRST,
  SEEK_SECOND,
  IN_HEADER,
  IN_BODY
} deframe_phase_e;

typedef struct packed {
  logic [7:0] data;
  logic       fwd;
  logic       len_err;
  logic [9:0] pid;
  logic       eop;
  logic       lst;
} packet_byte_t;

// Tracks the deframer state and table, and holds the packet bytes still owed by the block.
class deframer_scoreboard;
  deframe_phase_e phase;
  int unsigned    hdr_cnt;
  logic [7:0]     hdr [6];
  logic [16:0]    body_left;
  bit             selected;
  bit             len_err;
  logic [15:0]    tbl_size [sfpd_pkg::TableDepth];
  logic [15:0]    tbl_rate [sfpd_pkg::TableDepth];
  logic [15:0]    tbl_skip [sfpd_pkg::TableDepth];
  bit             tbl_reported [sfpd_pkg::TableDepth];
  packet_byte_t   owed_bytes [$];
  int unsigned    errors;
  int unsigned    items;
  int unsigned    defines;
  int unsigned    packets;
  int unsigned    forwarded;
  int unsigned    len_errors;
  int unsigned    checked;

  function new();
    phase = SEEK_FIRST;
    hdr_cnt = 0;
    body_left = '0;
    selected = 0;
    len_err = 0;
    for (int i = 0; i < sfpd_pkg::TableDepth; i++) begin
      tbl_size[i] = '0;
      tbl_rate[i] = '0;
      tbl_skip[i] = '0;
      tbl_reported[i] = 0;
    end
  endfunction

  function logic [9:0] header_id();
    return {hdr[1][1:0], hdr[0]};
  endfunction

  function void owe(logic [7:0] data, bit eop, bit lst);
    packet_byte_t pb;
    pb.data = data;
    pb.fwd = selected;
    pb.len_err = len_err;
    pb.pid = header_id();
    pb.eop = eop;
    pb.lst = lst;
    owed_bytes.push_back(pb);
  endfunction

  // Advance the deframer by one accepted item and queue the bytes it releases.
  function void note_item(bit act, logic [7:0] data, bit cts, logic [9:0] idx,
                          logic [15:0] sz, logic [15:0] rt);
    logic [9:0]  id;
    logic [15:0] len;
    items++;
    if (act) begin
      defines++;
      // Defines aimed past the end of the table are dropped.
      if (idx < sfpd_pkg::TableDepth) begin
        tbl_size[idx] = sz;
        tbl_rate[idx] = rt;
        tbl_skip[idx] = (rt != 0) ? 16'd1 : 16'd0;
        tbl_reported[idx] = 0;
      end
      return;
    end
    case (phase)
      SEEK_FIRST: begin
        if (data == sfpd_pkg::SyncByte) phase = SEEK_SECOND;
      end
      SEEK_SECOND: begin
        if (data == sfpd_pkg::SyncByte) begin
          phase = IN_HEADER;
          hdr_cnt = 0;
        end else begin
          phase = SEEK_FIRST;
        end
      end
      IN_HEADER: begin
        hdr[hdr_cnt] = data;
        if (hdr_cnt < 5) begin
          hdr_cnt++;
        end else begin
          // Last header byte: length check, forward decision, then the header burst.
          id = header_id();
          len = {hdr[5], hdr[4]};
          len_err = 0;
          selected = 0;
          // An id with no table entry is neither flagged nor forwarded.
          if (id < sfpd_pkg::TableDepth) begin
            if ({1'b0, tbl_size[id]} + 17'd6 != {1'b0, len} && !tbl_reported[id]) begin
              tbl_reported[id] = 1;
              len_err = 1;
            end
            if (cts && tbl_size[id] != 0 && tbl_rate[id] != 0) begin
              tbl_skip[id] = tbl_skip[id] - 16'd1;
              if (tbl_skip[id] == 0) begin
                tbl_skip[id] = tbl_rate[id];
                selected = 1;
              end
            end
          end
          packets++;
          if (selected) forwarded++;
          if (len_err) len_errors++;
          owe(sfpd_pkg::SyncByte, 0, 0);
          owe(sfpd_pkg::SyncByte, 0, 0);
          for (int k = 0; k < 6; k++) owe(hdr[k], 0, k == 5);
          body_left = {1'b0, len} + 17'd1;
          hdr_cnt = 0;
          phase = IN_BODY;
        end
      end
      default: begin
        if (body_left != 0) body_left--;
        owe(data, body_left == 0, 1);
        if (body_left == 0) phase = SEEK_FIRST;
      end
    endcase
  endfunction

  task report(string msg);
    errors++;
    if (errors <= 25) $display("MISMATCH: %s", msg);
  endtask

  // Compare one delivered byte against the oldest owed byte, field by field.
  task check_result(logic [7:0] data, logic fwd, logic lerr, logic [9:0] pid,
                    logic eop, logic lst);
    packet_byte_t want;
    checked++;
    if (owed_bytes.size() == 0) begin
      report($sformatf("unexpected result byte %02h id %0d", data, pid));
      return;
    end
    want = owed_bytes.pop_front();
    if (data !== want.data)
      report($sformatf("result %0d out_byte %02h, want %02h", checked, data, want.data));
    if (fwd !== want.fwd)
      report($sformatf("result %0d forward %b, want %b", checked, fwd, want.fwd));
    if (lerr !== want.len_err)
      report($sformatf("result %0d length_error %b, want %b", checked, lerr, want.len_err));
    if (pid !== want.pid)
      report($sformatf("result %0d packet_id %0d, want %0d", checked, pid, want.pid));
    if (eop !== want.eop)
      report($sformatf("result %0d end_of_packet %b, want %b", checked, eop, want.eop));
    if (lst !== want.lst)
      report($sformatf("result %0d last %b, want %b", checked, lst, want.lst));
  endtask
endclass

module tb_sync_framed_packet_decimator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandomItems = 460;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic        action_i = 1'b0;
  logic [7:0]  data_byte_i = '0;
  logic        clear_to_send_i = 1'b0;
  logic [9:0]  entry_index_i = '0;
  logic [15:0] entry_size_i = '0;
  logic [15:0] entry_decimation_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  out_byte_o;
  logic        forward_o;
  logic        length_error_o;
  logic [9:0]  packet_id_o;
  logic        end_of_packet_o;
  logic        last_o;

  deframer_scoreboard sb = new();
  bit          steady = 0;
  int unsigned cycles = 0;
  logic [9:0]  id_pool [8];

  sync_framed_packet_decimator u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .push               (push),
    .full               (full),
    .action_i           (action_i),
    .data_byte_i        (data_byte_i),
    .clear_to_send_i    (clear_to_send_i),
    .entry_index_i      (entry_index_i),
    .entry_size_i       (entry_size_i),
    .entry_decimation_i (entry_decimation_i),
    .empty              (empty),
    .pop                (pop),
    .out_byte_o         (out_byte_o),
    .forward_o          (forward_o),
    .length_error_o     (length_error_o),
    .packet_id_o        (packet_id_o),
    .end_of_packet_o    (end_of_packet_o),
    .last_o             (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver: stalls at random about 11 percent of the time, never during the steady stretch.
  always @(negedge clk_i) begin
    pop <= steady || ($urandom_range(99) >= 11);
  end

  // Both handshakes are sampled at the rising edge; the run is capped by a cycle count.
  always @(posedge clk_i) begin
    cycles++;
    if (rst_ni && push && !full)
      sb.note_item(action_i, data_byte_i, clear_to_send_i, entry_index_i, entry_size_i,
                   entry_decimation_i);
    if (rst_ni && pop && !empty)
      sb.check_result(out_byte_o, forward_o, length_error_o, packet_id_o, end_of_packet_o,
                      last_o);
    if (cycles >= CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Hold push low with junk on the payload.
  task automatic idle_for(int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      push <= 1'b0;
      action_i <= 1'($urandom);
      data_byte_i <= 8'($urandom);
      clear_to_send_i <= 1'($urandom);
    end
  endtask

  task automatic send_item(bit act, logic [7:0] data, bit cts, logic [9:0] idx,
                           logic [15:0] sz, logic [15:0] rt);
    if (!steady && $urandom_range(99) < 11) idle_for(1);
    @(negedge clk_i);
    push <= 1'b1;
    action_i <= act;
    data_byte_i <= data;
    clear_to_send_i <= cts;
    entry_index_i <= idx;
    entry_size_i <= sz;
    entry_decimation_i <= rt;
    do @(posedge clk_i); while (full);
  endtask

  task automatic stream(logic [7:0] data, bit cts);
    send_item(1'b0, data, cts, 10'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic define_entry(logic [9:0] idx, logic [15:0] sz, logic [15:0] rt);
    send_item(1'b1, 8'($urandom), 1'($urandom), idx, sz, rt);
  endtask

  // Table entry with sizes and rates mostly small, sometimes zero or at the top.
  task automatic define_random();
    int unsigned r;
    int unsigned q;
    logic [15:0] sz;
    logic [15:0] rt;
    r = $urandom_range(99);
    q = $urandom_range(99);
    if (r < 15) sz = '0;
    else if (r < 25) sz = 16'hFFFF;
    else if (r < 35) sz = 16'($urandom);
    else sz = 16'($urandom_range(1, 8));
    if (q < 15) rt = '0;
    else if (q < 20) rt = 16'hFFFF;
    else rt = 16'($urandom_range(1, 4));
    define_entry(id_pool[$urandom_range(7)], sz, rt);
  endtask

  // Two sync bytes, six header bytes, then len+1 body bytes; defines may slip in between.
  task automatic send_packet(logic [15:0] id_word, logic [7:0] skip_a, logic [7:0] skip_b,
                             logic [15:0] len, bit cts, bit mix_defines);
    logic [7:0] hbytes [6];
    hbytes = '{id_word[7:0], id_word[15:8], skip_a, skip_b, len[7:0], len[15:8]};
    stream(sfpd_pkg::SyncByte, 1'($urandom));
    stream(sfpd_pkg::SyncByte, 1'($urandom));
    for (int k = 0; k < 6; k++) begin
      if (mix_defines && $urandom_range(99) < 4) define_random();
      stream(hbytes[k], (k == 5) ? cts : 1'($urandom));
    end
    for (int k = 0; k <= len; k++) begin
      if (mix_defines && $urandom_range(99) < 4) define_random();
      stream(8'($urandom), 1'($urandom));
    end
  endtask

  // Stop sending until every owed byte has been delivered.
  task automatic drain();
    @(negedge clk_i);
    push <= 1'b0;
    while (sb.owed_bytes.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned rounds;
    int unsigned r;
    int unsigned n;
    logic [9:0]  id;
    logic [15:0] len;
    logic [7:0]  junk;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: extreme table entries, a broken sync, and first-time length mismatches.
    define_entry(10'd1023, 16'hFFFF, 16'hFFFF);
    define_entry(10'd2, 16'd1, 16'd1);
    stream(sfpd_pkg::SyncByte, 1'b1);
    stream(8'h55, 1'b1);
    send_packet(16'hFC02, 8'hFF, 8'h00, 16'd0, 1'b1, 1'b0);
    send_packet(16'h03FF, 8'h00, 8'hFF, 16'd0, 1'b0, 1'b0);

    // Random: mostly well-formed packets over a small id pool, plus defines and noise.
    id_pool = '{10'd0, 10'd1023, 10'd2, 10'($urandom), 10'($urandom), 10'($urandom),
                10'($urandom), 10'($urandom)};
    rounds = 0;
    while (sb.items < RandomItems + 22) begin
      rounds++;
      steady = (rounds >= 14 && rounds < 22);
      if (rounds == 8) drain();
      r = $urandom_range(99);
      if (r < 12) begin
        define_random();
      end else if (r < 18) begin
        // Stray bytes between packets, never a sync byte.
        n = $urandom_range(1, 4);
        repeat (n) begin
          junk = 8'($urandom);
          if (junk == sfpd_pkg::SyncByte) junk = 8'h00;
          stream(junk, 1'($urandom));
        end
      end else if (r < 22) begin
        // A sync byte not followed by a second one.
        junk = 8'($urandom);
        if (junk == sfpd_pkg::SyncByte) junk = 8'hFF;
        stream(sfpd_pkg::SyncByte, 1'($urandom));
        stream(junk, 1'($urandom));
      end else begin
        id = id_pool[$urandom_range(7)];
        if ($urandom_range(3) != 0 && sb.tbl_size[id] <= 12) len = sb.tbl_size[id] + 16'd6;
        else len = 16'($urandom_range(12));
        send_packet({6'($urandom), id}, 8'($urandom), 8'($urandom), len,
                    $urandom_range(3) != 0, 1'b1);
      end
    end
    steady = 0;

    drain();
    repeat (20) @(posedge clk_i);
    if (sb.owed_bytes.size() != 0)
      sb.report($sformatf("%0d expected result bytes never arrived", sb.owed_bytes.size()));

    $display("Covered %0d items (%0d table defines) and %0d packets,", sb.items, sb.defines,
             sb.packets);
    $display("of which %0d forwarded and %0d flagged for length; %0d bytes checked.",
             sb.forwarded, sb.len_errors, sb.checked);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
